### sv/scer_pkg.sv
`default_nettype none

package scer_pkg;

    // Ramp length default and field widths
    localparam int RAMP_STEPS_DEF = 100;
    localparam int ANGLE_W        = 8;
    localparam int TIME_W         = 32;
    localparam int CODE_W         = 8;
    localparam int INTERVAL_W     = 16;
    localparam int POS_W          = 7;
    localparam int EASE_W         = 17;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;

    // Detector and mode codes
    localparam logic [CODE_W-1:0] PRESENT_CODE = 8'd10;
    localparam logic [CODE_W-1:0] OPEN_CHAR    = 8'h63;

    // Reset values of the configuration registers
    localparam logic [ANGLE_W-1:0]    CLOSED_RST   = 8'd0;
    localparam logic [ANGLE_W-1:0]    OPEN_RST     = 8'd180;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd20;

    // Q30 constants for the ease table
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSED   = 2'd0,
        REG_OPEN     = 2'd1,
        REG_INTERVAL = 2'd2
    } t_cfg_reg;

    // Motion state
    typedef enum logic [1:0] {
        MOT_CLOSED  = 2'd0,
        MOT_OPENING = 2'd1,
        MOT_OPEN    = 2'd2,
        MOT_CLOSING = 2'd3
    } t_motion;

    // Result of one tick of the control stage
    typedef struct packed {
        logic    written;
        t_motion motion;
    } t_step;

    // Raised-cosine ease in Q16 from the half-angle offset a (Q30).
    // Only evaluated on constants while the table is built.
    function automatic logic [EASE_W-1:0] ease_q16(input logic [63:0] a, input logic upper);
        logic [63:0] a2;
        logic [63:0] sub;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] e2;
        logic [63:0] e16;
        a2  = (a * a) >> 30;
        // sine by a Horner series, innermost term first
        sub = ((a2 * ONE_Q30) >> 30) / 110;
        r   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
        sub = ((a2 * r) >> 30) / 72;
        r   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
        sub = ((a2 * r) >> 30) / 42;
        r   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
        sub = ((a2 * r) >> 30) / 20;
        r   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
        sub = ((a2 * r) >> 30) / 6;
        r   = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
        s   = (a * r) >> 30;
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        e2  = upper ? ONE_Q30 + s : ONE_Q30 - s;
        e16 = (e2 + 64'd16384) >> 15;
        return e16[EASE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/scer_ctrl.sv
`default_nettype none

module scer_ctrl
    import scer_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEF,
    parameter int CNT_W      = $clog2(RAMP_STEPS + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_a_valid,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic [CODE_W-1:0]     i_detect_state,
    input  wire logic [CODE_W-1:0]     i_mode_char,
    input  wire logic [INTERVAL_W-1:0] i_interval,
    input  wire logic                  i_c_ready,
    output      logic                  o_b_ready,
    output      logic                  o_b_valid,
    output      t_step                 o_step,
    output      logic [CNT_W-1:0]      o_count
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(RAMP_STEPS);

    t_motion             r_motion, n_motion;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TIME_W-1:0]   r_last, n_last;
    logic                r_written, n_written;
    logic                r_b_valid;
    logic                w_take;
    logic                w_due;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_close_req;
    logic                w_open_req;

    // stage handshake
    assign o_b_ready = !r_b_valid || i_c_ready;
    assign w_take    = i_a_valid && o_b_ready;

    // step timing, wrapping subtraction
    assign w_elapsed   = i_now_ms - r_last;
    assign w_due       = w_elapsed > {{(TIME_W-INTERVAL_W){1'b0}}, i_interval};
    assign w_close_req = (i_detect_state != PRESENT_CODE) && (r_motion != MOT_CLOSED);
    assign w_open_req  = (i_detect_state == PRESENT_CODE) && (i_mode_char == OPEN_CHAR)
                         && (r_motion != MOT_OPEN);

    // counter, timestamp and write flag
    always_comb begin
        n_count   = r_count;
        n_last    = r_last;
        n_written = 1'b0;
        if (w_close_req && w_due) begin
            n_last    = i_now_ms;
            n_written = 1'b1;
            if (r_count != '0) begin
                n_count = r_count - 1'b1;
            end
        end else if (w_open_req) begin
            if (w_due) begin
                n_last    = i_now_ms;
                n_written = 1'b1;
                if (r_count < CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
            if (n_count >= CNT_MAX) begin
                n_count = CNT_MAX;
            end
        end
    end

    // motion next state
    always_comb begin
        n_motion = r_motion;
        if (w_close_req) begin
            if (w_due) begin
                n_motion = MOT_CLOSING;
            end
            if (n_count == '0) begin
                n_motion = MOT_CLOSED;
            end
        end else if (w_open_req) begin
            if (w_due) begin
                n_motion = MOT_OPENING;
            end
            if (n_count >= CNT_MAX) begin
                n_motion = MOT_OPEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion  <= MOT_CLOSED;
            r_count   <= '0;
            r_last    <= '0;
            r_written <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_b_ready) begin
                r_b_valid <= i_a_valid;
            end
            if (w_take) begin
                r_motion  <= n_motion;
                r_count   <= n_count;
                r_last    <= n_last;
                r_written <= n_written;
            end
        end
    end

    // stage outputs
    assign o_b_valid      = r_b_valid;
    assign o_step.written = r_written;
    assign o_step.motion  = r_motion;
    assign o_count        = r_count;

endmodule

`default_nettype wire

### sv/scer_angle.sv
`default_nettype none

module scer_angle
    import scer_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEF,
    parameter int CNT_W      = $clog2(RAMP_STEPS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_b_valid,
    input  wire t_step              i_step,
    input  wire logic [CNT_W-1:0]   i_count,
    input  wire logic [ANGLE_W-1:0] i_closed_angle,
    input  wire logic [ANGLE_W-1:0] i_open_angle,
    input  wire logic               i_out_stall,
    output      logic               o_c_ready,
    output      logic               o_out_valid,
    output      logic [ANGLE_W-1:0] o_servo_angle,
    output      logic               o_angle_written,
    output      logic [1:0]         o_motion_state,
    output      logic [POS_W-1:0]   o_ramp_position
);

    logic [EASE_W-1:0]          w_ease [0:RAMP_STEPS];
    logic [ANGLE_W-1:0]         w_span;
    logic [ANGLE_W+EASE_W-1:0]  w_prod;
    logic [ANGLE_W:0]           w_raw;
    logic [ANGLE_W-1:0]         w_angle;
    logic [CNT_W+POS_W-1:0]     w_pos_ext;
    logic                       w_load;

    logic                       r_out_valid;
    logic [ANGLE_W-1:0]         r_angle;
    logic                       r_written;
    t_motion                    r_motion;
    logic [POS_W-1:0]           r_pos;

    // ease table, one entry per ramp position, built at elaboration
    for (genvar g = 0; g <= RAMP_STEPS; g++) begin : g_ease
        localparam int          D     = (2 * g >= RAMP_STEPS) ? 2 * g - RAMP_STEPS
                                                              : RAMP_STEPS - 2 * g;
        localparam logic [63:0] A_Q30 = (PI_Q30 * 64'(D)) / 64'(2 * RAMP_STEPS);
        assign w_ease[g] = ease_q16(A_Q30, (2 * g >= RAMP_STEPS));
    end

    // offset into the span, then clamp to closed..open
    assign w_span = (i_open_angle > i_closed_angle) ? i_open_angle - i_closed_angle
                                                    : '0;
    assign w_prod = w_span * w_ease[i_count];
    // offset never exceeds the span, so the bits above the angle width stay zero
    assign w_raw  = {1'b0, i_closed_angle} + {1'b0, w_prod[ANGLE_W+15:16]};

    always_comb begin
        w_angle = w_raw[ANGLE_W-1:0];
        if (w_raw > {1'b0, i_open_angle}) begin
            w_angle = i_open_angle;
        end
        if (w_angle < i_closed_angle) begin
            w_angle = i_closed_angle;
        end
    end

    assign w_pos_ext = {{POS_W{1'b0}}, i_count};

    // output register
    assign o_c_ready = !r_out_valid || !i_out_stall;
    assign w_load    = i_b_valid && o_c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_angle     <= CLOSED_RST;
        end else begin
            if (o_c_ready) begin
                r_out_valid <= i_b_valid;
            end
            if (w_load && i_step.written) begin
                r_angle <= w_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_written <= i_step.written;
            r_motion  <= i_step.motion;
            r_pos     <= w_pos_ext[POS_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_servo_angle   = r_angle;
    assign o_angle_written = r_written;
    assign o_motion_state  = r_motion;
    assign o_ramp_position = r_pos;

endmodule

`default_nettype wire

### sv/servo_cosine_ease_ramp_top.sv
// Raised-cosine servo ramp.
// Input channel (i_in_valid / o_in_stall) takes one tick request per cycle
// while o_in_stall is low: millisecond time, detector state and mode
// character. Output channel (o_out_valid / i_out_stall) returns one result
// per request, in order: commanded angle, step flag, motion state and ramp
// position. A result passes the input register, control stage and angle
// output register, in order. Throughput: one request per cycle when not
// stalled; the ramp state is updated in the single control stage, so
// back-to-back ticks see each other's steps.
// The angle is looked up from a raised-cosine ease table built at
// elaboration, scaled by one 8x17 multiply and clamped.
// Configuration writes (i_cfg_wr_en, i_cfg_index, i_cfg_data) take effect at
// the clock edge; index 3 is ignored. Write only while the block is idle.
// Reset (synchronous, active low) empties the pipeline, sets motion closed,
// counter and last step time to 0, angle 0, and the registers to 0/180/20.
// When i_out_stall is high the result holds; the stages behind it fill and
// o_in_stall rises once all three are occupied.
`default_nettype none

module servo_cosine_ease_ramp_top
    import scer_pkg::*;
#(
    parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic [CODE_W-1:0]     i_detect_state,
    input  wire logic [CODE_W-1:0]     i_mode_char,
    // result channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [ANGLE_W-1:0]    o_servo_angle,
    output      logic                  o_angle_written,
    output      logic [1:0]            o_motion_state,
    output      logic [POS_W-1:0]      o_ramp_position
);

    localparam int CNT_W = $clog2(RAMP_STEPS + 1);

    logic [ANGLE_W-1:0]    r_closed;
    logic [ANGLE_W-1:0]    r_open;
    logic [INTERVAL_W-1:0] r_interval;

    logic                  r_a_valid;
    logic [TIME_W-1:0]     r_a_now;
    logic [CODE_W-1:0]     r_a_det;
    logic [CODE_W-1:0]     r_a_mode;
    logic                  w_a_ready;

    logic                  w_b_ready;
    logic                  w_b_valid;
    t_step                 w_step;
    logic [CNT_W-1:0]      w_count;
    logic                  w_c_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed   <= CLOSED_RST;
            r_open     <= OPEN_RST;
            r_interval <= INTERVAL_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_CLOSED:   r_closed   <= i_cfg_data[ANGLE_W-1:0];
                REG_OPEN:     r_open     <= i_cfg_data[ANGLE_W-1:0];
                REG_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign w_a_ready  = !r_a_valid || w_b_ready;
    assign o_in_stall = !w_a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_a_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_a_ready) begin
            r_a_now  <= i_now_ms;
            r_a_det  <= i_detect_state;
            r_a_mode <= i_mode_char;
        end
    end

    // ramp control and state
    scer_ctrl #(
        .RAMP_STEPS (RAMP_STEPS),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_a_valid      (r_a_valid),
        .i_now_ms       (r_a_now),
        .i_detect_state (r_a_det),
        .i_mode_char    (r_a_mode),
        .i_interval     (r_interval),
        .i_c_ready      (w_c_ready),
        .o_b_ready      (w_b_ready),
        .o_b_valid      (w_b_valid),
        .o_step         (w_step),
        .o_count        (w_count)
    );

    // angle lookup and result register
    scer_angle #(
        .RAMP_STEPS (RAMP_STEPS),
        .CNT_W      (CNT_W)
    ) u_angle (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_b_valid       (w_b_valid),
        .i_step          (w_step),
        .i_count         (w_count),
        .i_closed_angle  (r_closed),
        .i_open_angle    (r_open),
        .i_out_stall     (i_out_stall),
        .o_c_ready       (w_c_ready),
        .o_out_valid     (o_out_valid),
        .o_servo_angle   (o_servo_angle),
        .o_angle_written (o_angle_written),
        .o_motion_state  (o_motion_state),
        .o_ramp_position (o_ramp_position)
    );

endmodule

`default_nettype wire
